// File: rtl/core/hrbd_pkg.sv
package hrbd_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam logic [31:0] LIMIT_RESET = 32'd1048576;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int CL_LEN = 14;
  localparam int TE_LEN = 17;
  localparam int CK_LEN = 8;
  localparam logic [4:0] NAME_POS_MAX = 5'd31;

  localparam logic [7:0] CL_NAME [CL_LEN] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h"
  };
  localparam logic [7:0] TE_NAME [TE_LEN] = '{
    "T", "r", "a", "n", "s", "f", "e", "r", "-",
    "E", "n", "c", "o", "d", "i", "n", "g"
  };
  localparam logic [7:0] CK_VAL [CK_LEN] = '{
    " ", "c", "h", "u", "n", "k", "e", "d"
  };

  typedef enum logic [2:0] {
    PH_HEAD     = 3'd0,
    PH_LEN_BODY = 3'd1,
    PH_CK_SIZE  = 3'd2,
    PH_CK_DATA  = 3'd3,
    PH_CK_CR    = 3'd4,
    PH_CK_LF    = 3'd5,
    PH_IDLE     = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_BODY       = 3'd0,
    EV_HDR_DONE   = 3'd1,
    EV_CHUNK_SIZE = 3'd2,
    EV_MSG_DONE   = 3'd3,
    EV_ERROR      = 3'd4
  } evt_t;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_LENGTH  = 2'd1,
    MODE_CHUNKED = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    NUM_START  = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_message;
  } item_t;

  typedef struct packed {
    evt_t        evt;
    logic [7:0]  data;
    mode_t       mode;
    logic [31:0] length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       line_empty;
    logic       colon_seen;
    logic [4:0] nm_pos;
    logic [1:0] nm_flags;
    logic [3:0] vm_pos;
    logic       vm_ok;
    num_phase_t num_phase;
    logic       num_neg;
  } line_t;

  function automatic line_t line_init();
    line_t r;
    r.line_empty = 1'b1;
    r.colon_seen = 1'b0;
    r.nm_pos     = '0;
    r.nm_flags   = 2'b11;
    r.vm_pos     = '0;
    r.vm_ok      = 1'b1;
    r.num_phase  = NUM_START;
    r.num_neg    = 1'b0;
    return r;
  endfunction

  function automatic logic cl_match(input logic [4:0] pos, input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (pos < 5'(CL_LEN)) r = (CL_NAME[pos[3:0]] == c);
    return r;
  endfunction

  function automatic logic te_match(input logic [4:0] pos, input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (pos < 5'(TE_LEN)) r = (TE_NAME[pos] == c);
    return r;
  endfunction

  function automatic logic ck_match(input logic [3:0] pos, input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (pos < 4'(CK_LEN)) r = (CK_VAL[pos[2:0]] == c);
    return r;
  endfunction

endpackage

// File: rtl/core/hrbd_in_stage.sv
module hrbd_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      rx_byte,
  input  logic            new_message,
  input  logic            advance,
  output logic            hold_valid,
  output hrbd_pkg::item_t item
);

  logic take;

  // Stall only while the held byte cannot move on this cycle.
  assign in_stall = hold_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.rx_byte     <= rx_byte;
      item.new_message <= new_message;
    end
  end

endmodule

// File: rtl/core/hrbd_parser.sv
module hrbd_parser #(
  parameter int LENGTH_BITS = hrbd_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  hrbd_pkg::item_t   item,
  input  logic [31:0]       length_limit,
  output logic              emit,
  output hrbd_pkg::result_t res
);

  localparam int CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  hrbd_pkg::phase_t       phase, phase_next, e_phase;
  hrbd_pkg::mode_t        mode_reg, mode_reg_next, e_mode;
  hrbd_pkg::line_t        line, line_next, e_line, line_mid, line_fin;
  logic                   prev_was_cr, prev_was_cr_next, e_prev_cr;
  logic                   is_status_line, is_status_line_next, e_is_status;
  logic [LENGTH_BITS-1:0] number_accum, number_accum_next, e_acc;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next, e_bytes_left;

  logic [7:0]             c;
  logic                   is_digit, is_hex_up, is_hex_lo, is_hex, head_eol;
  logic [LENGTH_BITS+3:0] dec_wide, hex_wide;
  logic [LENGTH_BITS-1:0] dec_sat, hex_sat, bl_dec;
  logic [3:0]             hex_d;
  logic [CMP_W-1:0]       bl_w, acc_w, lim_w;
  logic                   bl_over, acc_over, dec_upd, len_none;

  // One header byte against the line state; the accumulator is handled outside.
  function automatic hrbd_pkg::line_t feed(input hrbd_pkg::line_t l, input logic status,
                                           input logic [7:0] ch);
    hrbd_pkg::line_t r;
    r = l;
    r.line_empty = 1'b0;
    if (!status) begin
      if (!l.colon_seen) begin
        if (ch == ":") begin
          r.colon_seen = 1'b1;
          r.nm_flags[0] = l.nm_flags[0] && (l.nm_pos == 5'(hrbd_pkg::CL_LEN));
          r.nm_flags[1] = l.nm_flags[1] && (l.nm_pos == 5'(hrbd_pkg::TE_LEN));
        end else begin
          if (!hrbd_pkg::cl_match(l.nm_pos, ch)) r.nm_flags[0] = 1'b0;
          if (!hrbd_pkg::te_match(l.nm_pos, ch)) r.nm_flags[1] = 1'b0;
          if (l.nm_pos < hrbd_pkg::NAME_POS_MAX) r.nm_pos = l.nm_pos + 5'd1;
        end
      end else begin
        if (l.vm_ok && hrbd_pkg::ck_match(l.vm_pos, ch)) begin
          r.vm_pos = l.vm_pos + 4'd1;
        end else begin
          r.vm_ok = 1'b0;
        end
        if (l.num_phase == hrbd_pkg::NUM_START &&
            (ch == " " || (ch >= 8'd9 && ch <= 8'd13))) begin
          r.num_phase = hrbd_pkg::NUM_START;
        end else if (l.num_phase == hrbd_pkg::NUM_START && ch == "+") begin
          r.num_phase = hrbd_pkg::NUM_DIGITS;
        end else if (l.num_phase == hrbd_pkg::NUM_START && ch == "-") begin
          r.num_neg   = 1'b1;
          r.num_phase = hrbd_pkg::NUM_DIGITS;
        end else if (l.num_phase != hrbd_pkg::NUM_DONE && ch >= "0" && ch <= "9") begin
          r.num_phase = hrbd_pkg::NUM_DIGITS;
        end else begin
          r.num_phase = hrbd_pkg::NUM_DONE;
        end
      end
    end
    return r;
  endfunction

  // Apply a message restart before the byte itself is looked at.
  always_comb begin
    if (item.new_message) begin
      e_phase      = hrbd_pkg::PH_HEAD;
      e_prev_cr    = 1'b0;
      e_is_status  = 1'b1;
      e_mode       = hrbd_pkg::MODE_NONE;
      e_bytes_left = '0;
      e_line       = hrbd_pkg::line_init();
      e_acc        = '0;
    end else begin
      e_phase      = phase;
      e_prev_cr    = prev_was_cr;
      e_is_status  = is_status_line;
      e_mode       = mode_reg;
      e_bytes_left = bytes_left;
      e_line       = line;
      e_acc        = number_accum;
    end
  end

  assign c         = item.rx_byte;
  assign is_digit  = (c >= "0") && (c <= "9");
  assign is_hex_up = (c >= "A") && (c <= "F");
  assign is_hex_lo = (c >= "a") && (c <= "f");
  assign is_hex    = is_digit || is_hex_up || is_hex_lo;
  assign hex_d     = is_digit ? c[3:0] : (c[3:0] + 4'd9);
  assign head_eol  = e_prev_cr && (c == hrbd_pkg::CH_LF);

  // acc * 10 + d, saturating
  assign dec_wide = ({4'b0, e_acc} << 3) + ({4'b0, e_acc} << 1) + {LENGTH_BITS'(0), c[3:0]};
  assign dec_sat  = (|dec_wide[LENGTH_BITS+3:LENGTH_BITS]) ? LEN_MAX
                                                           : dec_wide[LENGTH_BITS-1:0];
  // acc * 16 + d, saturating
  assign hex_wide = {e_acc, hex_d};
  assign hex_sat  = (|e_acc[LENGTH_BITS-1:LENGTH_BITS-4]) ? LEN_MAX
                                                         : hex_wide[LENGTH_BITS-1:0];

  assign bl_dec   = e_bytes_left - LENGTH_BITS'(1);
  assign bl_w     = CMP_W'(e_bytes_left);
  assign acc_w    = CMP_W'(e_acc);
  assign lim_w    = CMP_W'(length_limit);
  assign bl_over  = bl_w > lim_w;
  assign acc_over = acc_w > lim_w;
  assign len_none = e_line.num_neg || (e_acc == '0);

  assign line_mid = e_prev_cr ? feed(e_line, e_is_status, hrbd_pkg::CH_CR) : e_line;
  assign line_fin = feed(line_mid, e_is_status, c);
  assign dec_upd  = !e_is_status && line_mid.colon_seen &&
                    (line_mid.num_phase != hrbd_pkg::NUM_DONE) && is_digit;

  // Next state
  always_comb begin
    phase_next          = e_phase;
    prev_was_cr_next    = e_prev_cr;
    is_status_line_next = e_is_status;
    mode_reg_next       = e_mode;
    bytes_left_next     = e_bytes_left;
    line_next           = e_line;
    number_accum_next   = e_acc;
    unique case (e_phase)
      hrbd_pkg::PH_HEAD: begin
        if (head_eol) begin
          prev_was_cr_next = 1'b0;
          if (e_line.line_empty) begin
            if (e_mode == hrbd_pkg::MODE_LENGTH) begin
              phase_next = bl_over ? hrbd_pkg::PH_IDLE : hrbd_pkg::PH_LEN_BODY;
            end else if (e_mode == hrbd_pkg::MODE_CHUNKED) begin
              phase_next        = hrbd_pkg::PH_CK_SIZE;
              number_accum_next = '0;
            end else begin
              phase_next = hrbd_pkg::PH_IDLE;
            end
          end else begin
            if (!e_is_status && e_line.colon_seen) begin
              if (e_line.nm_flags[0]) begin
                mode_reg_next   = len_none ? hrbd_pkg::MODE_NONE : hrbd_pkg::MODE_LENGTH;
                bytes_left_next = len_none ? '0 : e_acc;
              end
              if (e_line.nm_flags[1] && e_line.vm_ok &&
                  e_line.vm_pos == 4'(hrbd_pkg::CK_LEN)) begin
                mode_reg_next = hrbd_pkg::MODE_CHUNKED;
              end
            end
            is_status_line_next = 1'b0;
            line_next           = hrbd_pkg::line_init();
            number_accum_next   = '0;
          end
        end else if (c == hrbd_pkg::CH_CR) begin
          prev_was_cr_next = 1'b1;
          line_next        = line_mid;
        end else begin
          prev_was_cr_next = 1'b0;
          line_next        = line_fin;
          if (dec_upd) number_accum_next = dec_sat;
        end
      end
      hrbd_pkg::PH_LEN_BODY: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) phase_next = hrbd_pkg::PH_IDLE;
      end
      hrbd_pkg::PH_CK_SIZE: begin
        if (e_prev_cr && c == hrbd_pkg::CH_LF) begin
          prev_was_cr_next = 1'b0;
          if (acc_over) begin
            phase_next = hrbd_pkg::PH_IDLE;
          end else begin
            bytes_left_next = e_acc;
            phase_next = (e_acc != '0) ? hrbd_pkg::PH_CK_DATA : hrbd_pkg::PH_CK_CR;
          end
        end else begin
          prev_was_cr_next = (c == hrbd_pkg::CH_CR);
          if (is_hex) number_accum_next = hex_sat;
        end
      end
      hrbd_pkg::PH_CK_DATA: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) phase_next = hrbd_pkg::PH_CK_CR;
      end
      hrbd_pkg::PH_CK_CR: begin
        phase_next = (c == hrbd_pkg::CH_CR) ? hrbd_pkg::PH_CK_LF : hrbd_pkg::PH_IDLE;
      end
      hrbd_pkg::PH_CK_LF: begin
        if (c != hrbd_pkg::CH_LF || e_acc == '0) begin
          phase_next = hrbd_pkg::PH_IDLE;
        end else begin
          phase_next        = hrbd_pkg::PH_CK_SIZE;
          number_accum_next = '0;
          prev_was_cr_next  = 1'b0;
        end
      end
      hrbd_pkg::PH_IDLE: begin
        phase_next = hrbd_pkg::PH_IDLE;
      end
      default: begin
        phase_next = hrbd_pkg::PH_IDLE;
      end
    endcase
  end

  // Result for this byte
  always_comb begin
    emit       = 1'b0;
    res.evt    = hrbd_pkg::EV_BODY;
    res.data   = '0;
    res.mode   = e_mode;
    res.length = '0;
    res.last   = 1'b0;
    unique case (e_phase)
      hrbd_pkg::PH_HEAD: begin
        if (head_eol && e_line.line_empty) begin
          emit = 1'b1;
          if (e_mode == hrbd_pkg::MODE_LENGTH) begin
            if (bl_over) begin
              res.evt  = hrbd_pkg::EV_ERROR;
              res.last = 1'b1;
            end else begin
              res.evt    = hrbd_pkg::EV_HDR_DONE;
              res.length = bl_w[31:0];
            end
          end else begin
            res.evt  = hrbd_pkg::EV_HDR_DONE;
            res.last = (e_mode != hrbd_pkg::MODE_CHUNKED);
          end
        end
      end
      hrbd_pkg::PH_LEN_BODY: begin
        emit     = 1'b1;
        res.data = c;
        res.last = (bl_dec == '0);
      end
      hrbd_pkg::PH_CK_SIZE: begin
        if (e_prev_cr && c == hrbd_pkg::CH_LF) begin
          emit = 1'b1;
          if (acc_over) begin
            res.evt  = hrbd_pkg::EV_ERROR;
            res.last = 1'b1;
          end else begin
            res.evt    = hrbd_pkg::EV_CHUNK_SIZE;
            res.length = acc_w[31:0];
          end
        end
      end
      hrbd_pkg::PH_CK_DATA: begin
        emit     = 1'b1;
        res.data = c;
      end
      hrbd_pkg::PH_CK_CR: begin
        if (c != hrbd_pkg::CH_CR) begin
          emit     = 1'b1;
          res.evt  = hrbd_pkg::EV_ERROR;
          res.last = 1'b1;
        end
      end
      hrbd_pkg::PH_CK_LF: begin
        if (c != hrbd_pkg::CH_LF) begin
          emit     = 1'b1;
          res.evt  = hrbd_pkg::EV_ERROR;
          res.last = 1'b1;
        end else if (e_acc == '0) begin
          emit     = 1'b1;
          res.evt  = hrbd_pkg::EV_MSG_DONE;
          res.last = 1'b1;
        end
      end
      hrbd_pkg::PH_IDLE: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hrbd_pkg::PH_HEAD;
      prev_was_cr    <= 1'b0;
      is_status_line <= 1'b1;
      mode_reg       <= hrbd_pkg::MODE_NONE;
      bytes_left     <= '0;
      line           <= hrbd_pkg::line_init();
      number_accum   <= '0;
    end else if (step_en) begin
      phase          <= phase_next;
      prev_was_cr    <= prev_was_cr_next;
      is_status_line <= is_status_line_next;
      mode_reg       <= mode_reg_next;
      bytes_left     <= bytes_left_next;
      line           <= line_next;
      number_accum   <= number_accum_next;
    end
  end

`ifndef SYNTHESIS
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && emit && res.last |=> phase == hrbd_pkg::PH_IDLE)
    else $error("final result did not park the parser");
  a_len_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == hrbd_pkg::PH_LEN_BODY |-> bytes_left != '0)
    else $error("length body entered with no bytes left");
  a_ck_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == hrbd_pkg::PH_CK_DATA |-> bytes_left != '0)
    else $error("chunk data entered with no bytes left");
`endif

endmodule

// File: rtl/core/hrbd_out_stage.sv
module hrbd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hrbd_pkg::result_t res_in,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        event_res,
  output logic [7:0]        data_byte,
  output logic [1:0]        body_mode,
  output logic [31:0]       length_value,
  output logic              last
);

  hrbd_pkg::result_t held;

  // Free when empty, or when the held result transfers this cycle.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= res_in;
  end

  assign event_res    = held.evt;
  assign data_byte    = held.data;
  assign body_mode    = held.mode;
  assign length_value = held.length;
  assign last         = held.last;

endmodule

// File: rtl/core/http_response_body_deframer.sv
// Channel   Handshake             Payload
// -------   -------------------   ------------------------------------------------
// in        in_valid / in_stall   rx_byte, new_message
// out       out_valid / out_stall event_res, data_byte, body_mode, length_value, last
// cfg       cfg_wr_en             cfg_wr_data (length_limit)
//
// One byte per cycle while the output is not stalled: each byte waits in the input register and
// is parsed by combinational logic into the result register.
// Sustained rate is one byte per cycle unless the output stalls, set by the parser state update per byte.
// rst is synchronous, active high; it restores the length limit to 1048576 and
// the parser to the start of a status line.
// A stalled output blocks only bytes that produce a result; header bytes keep flowing.
module http_response_body_deframer #(
  parameter int LENGTH_BITS = hrbd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        new_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [1:0]  body_mode,
  output logic [31:0] length_value,
  output logic        last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic              hold_valid;
  logic              advance;
  logic              emit;
  logic              out_free;
  logic [31:0]       length_limit;
  hrbd_pkg::item_t   item;
  hrbd_pkg::result_t res;

  // Length limit register; the user must write it only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= hrbd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      length_limit <= cfg_wr_data;
    end
  end

  // Advance the held byte when its result has room, or when it makes none.
  assign advance = hold_valid && (!emit || out_free);

  hrbd_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .new_message (new_message),
    .advance     (advance),
    .hold_valid  (hold_valid),
    .item        (item)
  );

  hrbd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step_en      (advance),
    .item         (item),
    .length_limit (length_limit),
    .emit         (emit),
    .res          (res)
  );

  hrbd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && emit),
    .res_in       (res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .body_mode    (body_mode),
    .length_value (length_value),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && emit && out_valid && out_stall)
    else $error("input stalled without a blocked result");
  a_no_silent_load: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid)
    else $error("parsed result did not reach the output register");
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != 3'(hrbd_pkg::EV_BODY) |-> data_byte == 8'd0)
    else $error("data byte set on a non-body result");
`endif

endmodule

// File: sim/tb_http_response_body_deframer.sv
module tb_http_response_body_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling: roughly a thousand bytes, each waiting out a few
  // random gaps and stalls, fit many times over.
  localparam int CYCLE_LIMIT = 400000;
  // Margin for the input and result registers to empty before the block counts as quiet.
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BYTES_PER_PHASE = 30;

  // Header names and the one accepted Transfer-Encoding value, first char on the left.
  localparam logic [8*hrbd_pkg::TE_LEN-1:0] CL_TEXT = "Content-Length";
  localparam logic [8*hrbd_pkg::TE_LEN-1:0] TE_TEXT = "Transfer-Encoding";
  localparam logic [8*hrbd_pkg::TE_LEN-1:0] CK_TEXT = " chunked";

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        new_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [1:0]  body_mode;
  logic [31:0] length_value;
  logic        last;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Results the parser should produce, oldest first.
  hrbd_pkg::result_t expected_events[$];
  // Bytes of the message being built for transmission.
  logic [7:0]  msg_q[$];

  http_response_body_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .new_message  (new_message),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .body_mode    (body_mode),
    .length_value (length_value),
    .last         (last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deframer state mirror. Updated once per accepted transfer on the input side.
  // ---------------------------------------------------------------------------
  logic [31:0]          limit;
  hrbd_pkg::phase_t     ph;
  hrbd_pkg::mode_t      mode;
  logic                 prev_cr;
  logic                 status_line;
  logic [63:0]          acc;
  logic [63:0]          left;
  logic                 line_empty;
  logic                 colon_seen;
  logic [4:0]           nm_pos;
  logic [1:0]           nm_flags;   // bit 0: Content-Length alive, bit 1: Transfer-Encoding alive
  logic [3:0]           vm_pos;
  logic                 vm_ok;
  hrbd_pkg::num_phase_t num_ph;
  logic                 num_neg;

  function automatic logic [7:0] text_char(input logic [8*hrbd_pkg::TE_LEN-1:0] t,
                                           input int n, input int i);
    return t[(n-1-i)*8 +: 8];
  endfunction

  // Multiply-accumulate that clamps at the all-ones length value.
  function automatic logic [63:0] sat_mac(input logic [63:0] a, input logic [63:0] radix,
                                          input logic [63:0] digit);
    logic [63:0] top;
    top = (64'd1 << hrbd_pkg::LENGTH_BITS_DEF) - 64'd1;
    if (a > (top - digit) / radix) return top;
    return a * radix + digit;
  endfunction

  function automatic void clear_line();
    line_empty = 1'b1;
    colon_seen = 1'b0;
    nm_pos     = '0;
    nm_flags   = 2'b11;
    vm_pos     = '0;
    vm_ok      = 1'b1;
    num_ph     = hrbd_pkg::NUM_START;
    num_neg    = 1'b0;
    acc        = '0;
  endfunction

  function automatic void start_message();
    ph          = hrbd_pkg::PH_HEAD;
    prev_cr     = 1'b0;
    status_line = 1'b1;
    mode        = hrbd_pkg::MODE_NONE;
    left        = '0;
    clear_line();
  endfunction

  function automatic void reset_model();
    limit = hrbd_pkg::LIMIT_RESET;
    start_message();
  endfunction

  function automatic void post_event(input hrbd_pkg::evt_t ev, input logic [7:0] d,
                                     input logic [63:0] len, input logic lst);
    hrbd_pkg::result_t r;
    r.evt    = ev;
    r.data   = d;
    r.mode   = mode;
    r.length = len[31:0];
    r.last   = lst;
    expected_events.push_back(r);
  endfunction

  function automatic void flag_error();
    ph = hrbd_pkg::PH_IDLE;
    post_event(hrbd_pkg::EV_ERROR, 8'd0, 64'd0, 1'b1);
  endfunction

  // Consume one character of a header line (CR LF already stripped).
  function automatic void feed_char(input logic [7:0] c);
    logic [1:0] hit;
    line_empty = 1'b0;
    if (status_line) return;
    if (!colon_seen) begin
      if (c == ":") begin
        // Only the first colon splits; lock in the names that matched fully.
        hit = 2'b00;
        colon_seen = 1'b1;
        if (nm_flags[0] && nm_pos == hrbd_pkg::CL_LEN) hit[0] = 1'b1;
        if (nm_flags[1] && nm_pos == hrbd_pkg::TE_LEN) hit[1] = 1'b1;
        nm_flags = hit;
        return;
      end
      if (nm_pos >= hrbd_pkg::CL_LEN ||
          text_char(CL_TEXT, hrbd_pkg::CL_LEN, nm_pos) != c) nm_flags[0] = 1'b0;
      if (nm_pos >= hrbd_pkg::TE_LEN ||
          text_char(TE_TEXT, hrbd_pkg::TE_LEN, nm_pos) != c) nm_flags[1] = 1'b0;
      if (nm_pos < hrbd_pkg::NAME_POS_MAX) nm_pos++;
      return;
    end
    if (vm_ok && vm_pos < hrbd_pkg::CK_LEN &&
        text_char(CK_TEXT, hrbd_pkg::CK_LEN, vm_pos) == c) vm_pos++;
    else vm_ok = 1'b0;
    // Decimal value: skip leading white space (tab through CR, space), one sign,
    // then digits until the first non-digit.
    if (num_ph == hrbd_pkg::NUM_START) begin
      if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return;
      if (c == "+") begin
        num_ph = hrbd_pkg::NUM_DIGITS;
        return;
      end
      if (c == "-") begin
        num_neg = 1'b1;
        num_ph = hrbd_pkg::NUM_DIGITS;
        return;
      end
    end
    if (num_ph != hrbd_pkg::NUM_DONE && c >= "0" && c <= "9") begin
      acc = sat_mac(acc, 64'd10, 64'(c - "0"));
      num_ph = hrbd_pkg::NUM_DIGITS;
    end else begin
      num_ph = hrbd_pkg::NUM_DONE;
    end
  endfunction

  function automatic void close_line();
    if (line_empty) begin
      // End of headers: the final mode decides the body framing.
      if (mode == hrbd_pkg::MODE_LENGTH) begin
        if (left > {32'd0, limit}) begin
          flag_error();
        end else begin
          ph = hrbd_pkg::PH_LEN_BODY;
          post_event(hrbd_pkg::EV_HDR_DONE, 8'd0, left, 1'b0);
        end
      end else if (mode == hrbd_pkg::MODE_CHUNKED) begin
        ph = hrbd_pkg::PH_CK_SIZE;
        acc = '0;
        post_event(hrbd_pkg::EV_HDR_DONE, 8'd0, 64'd0, 1'b0);
      end else begin
        ph = hrbd_pkg::PH_IDLE;
        post_event(hrbd_pkg::EV_HDR_DONE, 8'd0, 64'd0, 1'b1);
      end
      return;
    end
    if (!status_line && colon_seen) begin
      if (nm_flags[0]) begin
        if (num_neg || acc == 0) begin
          mode = hrbd_pkg::MODE_NONE;
          left = '0;
        end else begin
          mode = hrbd_pkg::MODE_LENGTH;
          left = acc;
        end
      end
      if (nm_flags[1] && vm_ok && vm_pos == hrbd_pkg::CK_LEN) mode = hrbd_pkg::MODE_CHUNKED;
    end
    status_line = 1'b0;
    clear_line();
  endfunction

  function automatic logic [63:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 64'(c - "0");
    if (c >= "A" && c <= "F") return 64'(c - "A") + 64'd10;
    return 64'(c - "a") + 64'd10;
  endfunction

  // Advance the mirror by one byte and queue the result it causes, if any.
  function automatic void deframe_byte(input logic [7:0] c, input logic restart);
    if (restart) start_message();
    case (ph)
      hrbd_pkg::PH_HEAD: begin
        if (prev_cr && c == hrbd_pkg::CH_LF) begin
          prev_cr = 1'b0;
          close_line();
        end else begin
          // A CR not followed by LF is plain line content.
          if (prev_cr) feed_char(hrbd_pkg::CH_CR);
          if (c == hrbd_pkg::CH_CR) begin
            prev_cr = 1'b1;
          end else begin
            prev_cr = 1'b0;
            feed_char(c);
          end
        end
      end
      hrbd_pkg::PH_LEN_BODY: begin
        left--;
        if (left == 0) begin
          ph = hrbd_pkg::PH_IDLE;
          post_event(hrbd_pkg::EV_BODY, c, 64'd0, 1'b1);
        end else begin
          post_event(hrbd_pkg::EV_BODY, c, 64'd0, 1'b0);
        end
      end
      hrbd_pkg::PH_CK_SIZE: begin
        if (prev_cr && c == hrbd_pkg::CH_LF) begin
          prev_cr = 1'b0;
          if (acc > {32'd0, limit}) begin
            flag_error();
          end else begin
            left = acc;
            ph = (acc != 0) ? hrbd_pkg::PH_CK_DATA : hrbd_pkg::PH_CK_CR;
            post_event(hrbd_pkg::EV_CHUNK_SIZE, 8'd0, acc, 1'b0);
          end
        end else begin
          prev_cr = (c == hrbd_pkg::CH_CR);
          // Anything that is not a hex digit is skipped.
          if ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            acc = sat_mac(acc, 64'd16, hex_value(c));
        end
      end
      hrbd_pkg::PH_CK_DATA: begin
        left--;
        if (left == 0) ph = hrbd_pkg::PH_CK_CR;
        post_event(hrbd_pkg::EV_BODY, c, 64'd0, 1'b0);
      end
      hrbd_pkg::PH_CK_CR: begin
        if (c != hrbd_pkg::CH_CR) flag_error();
        else ph = hrbd_pkg::PH_CK_LF;
      end
      hrbd_pkg::PH_CK_LF: begin
        if (c != hrbd_pkg::CH_LF) begin
          flag_error();
        end else if (acc == 0) begin
          ph = hrbd_pkg::PH_IDLE;
          post_event(hrbd_pkg::EV_MSG_DONE, 8'd0, 64'd0, 1'b1);
        end else begin
          ph = hrbd_pkg::PH_CK_SIZE;
          acc = '0;
          prev_cr = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, result checking, run timeout.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    hrbd_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: event_res %0d data_byte %0d length_value %0d",
               event_res, data_byte, length_value);
        mismatch_count++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", want.evt, event_res);
        check_field("data_byte", want.data, data_byte);
        check_field("body_mode", want.mode, body_mode);
        check_field("length_value", want.length, length_value);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the transfer completes, then advance the mirror.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    new_message <= restart;
    do @(posedge clk); while (in_stall);
    deframe_byte(b, restart);
  endtask

  // Drop valid and hold off until every queued result has arrived, then let the
  // pipeline empty out bytes that produce nothing.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit = v;
  endtask

  // In message text a '|' stands for CR LF; a lone CR is written as \015.
  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == "|") begin
        msg_q.push_back(hrbd_pkg::CH_CR);
        msg_q.push_back(hrbd_pkg::CH_LF);
      end else begin
        msg_q.push_back(s[i]);
      end
    end
  endfunction

  function automatic void put_random(input int n);
    repeat (n) msg_q.push_back(8'($urandom_range(255)));
  endfunction

  // Hex digits in mixed case, sometimes with leading zeros.
  function automatic void put_hex(input logic [63:0] v);
    logic [7:0] digits[$];
    logic [3:0] nib;
    do begin
      nib = v[3:0];
      if (nib < 10) digits.push_front(8'("0" + nib));
      else digits.push_front(8'(($urandom_range(1) ? "a" : "A") + nib - 10));
      v = v >> 4;
    end while (v != 0);
    repeat ($urandom_range(0, 2)) msg_q.push_back("0");
    foreach (digits[i]) msg_q.push_back(digits[i]);
  endfunction

  task automatic send_msg(input logic restart);
    foreach (msg_q[i]) send_byte(msg_q[i], restart && i == 0);
    msg_q.delete();
  endtask

  task automatic send_text(input string s, input logic restart);
    put_text(s);
    send_msg(restart);
  endtask

  // Chunked body: a few well-formed chunks and the zero chunk, with the odd
  // oversized size, broken CR LF or trailer line.
  function automatic void put_chunks();
    int chunk_len;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(19) == 0) begin
        put_hex(64'h1_0000_0000 + 64'($urandom));
        put_text("|");
        put_random($urandom_range(0, 4));
        return;
      end
      chunk_len = $urandom_range(1, ($urandom_range(3) == 0) ? 30 : 12);
      put_hex(chunk_len);
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1)) put_text(";z");
        else put_text(" \015;");
      end
      put_text("|");
      put_random(chunk_len);
      if ($urandom_range(14) == 0) begin
        if ($urandom_range(1)) msg_q.push_back(hrbd_pkg::CH_CR);
        msg_q.push_back("z");
        return;
      end
      put_text("|");
    end
    put_text("0|");
    if ($urandom_range(9) == 0) put_text("X-T: 1|");
    put_text("|");
  endfunction

  // One random message: mostly a proper response with random framing headers and
  // a body that fits them, sometimes cut short, sometimes plain noise.
  function automatic void compose_message();
    hrbd_pkg::mode_t plan;
    logic [63:0]     plan_len;
    int              value;
    int              kind;
    int              count;
    if ($urandom_range(9) == 0) begin
      put_random($urandom_range(1, 30));
      return;
    end
    if ($urandom_range(15) == 0) begin
      put_text("|");
      return;
    end
    if ($urandom_range(1)) put_text("HTTP/1.1 200 OK|");
    else put_text("HTTP/1.0 206 Partial|");
    plan = hrbd_pkg::MODE_NONE;
    plan_len = '0;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          value = ($urandom_range(3) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 24);
          kind = $urandom_range(0, 5);
          if (kind == 4) begin
            put_text("Content-Length: 99999999999|");
            plan = hrbd_pkg::MODE_LENGTH;
            plan_len = 64'hFFFF_FFFF;
          end else begin
            case (kind)
              0: put_text("Content-Length:");
              1: put_text("Content-Length:\t +");
              2: put_text("Content-Length: \n ");
              default: put_text("Content-Length: ");
            endcase
            if (kind == 3) put_text("-");
            put_text($sformatf("%0d", value));
            if ($urandom_range(3) == 0) put_text("x7");
            put_text("|");
            plan = (kind == 3 || value == 0) ? hrbd_pkg::MODE_NONE : hrbd_pkg::MODE_LENGTH;
            plan_len = value;
          end
        end
        3, 4: begin
          put_text("Transfer-Encoding: chunked|");
          plan = hrbd_pkg::MODE_CHUNKED;
        end
        5: begin
          case ($urandom_range(0, 3))
            0: put_text("Transfer-Encoding: Chunked|");
            1: put_text("Transfer-Encoding:chunked|");
            2: put_text("Transfer-Encoding: chunked |");
            default: put_text("Transfer-Encoding: gzip|");
          endcase
        end
        6: begin
          put_text("X-Id: ");
          repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(32, 126)));
          put_text("|");
        end
        7: put_text("Connection close|");
        8: begin
          case ($urandom_range(0, 3))
            0: put_text("Content-Length : 5|");
            1: put_text("content-length: 5|");
            2: put_text("Transfer-Encodin: chunked|");
            default: put_text("Content-Lengthh: 5|");
          endcase
        end
        default: begin
          put_random($urandom_range(1, 12));
          put_text("|");
        end
      endcase
    end
    put_text("|");
    case (plan)
      hrbd_pkg::MODE_LENGTH: begin
        count = (plan_len > 40) ? $urandom_range(0, 6) : int'(plan_len);
        if ($urandom_range(9) == 0) count = $urandom_range(0, count);
        put_random(count);
      end
      hrbd_pkg::MODE_CHUNKED: put_chunks();
      default: ;
    endcase
    // Trailing bytes after the end of a message must be dropped silently.
    if ($urandom_range(5) == 0) put_random($urandom_range(1, 5));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Line splitting: empty status line, lone CR and lone LF as content, a line
  // with no colon, framing text inside the status line.
  task automatic test_line_breaks();
    send_text("|", 1'b0);
    send_text("Content-Length: 5||", 1'b1);
    send_text("HTTP/1.1 200\015OK\n|Content-Length 9|Content-Length:\n\015 3||abc", 1'b1);
    // Restart in the middle of a header line.
    send_text("R|Content-Len", 1'b1);
    send_text("R|Content-Length: 2||ok", 1'b1);
  endtask

  // Decimal values: sign, trailing junk, negative, saturation, reset limit.
  task automatic test_content_length();
    send_text("R|Content-Length: +2x9||yz", 1'b1);
    send_text("R|Content-Length: -5||", 1'b1);
    send_text("R|Content-Length: 99999999999||", 1'b1);
    send_text("R|Content-Length: 1048576||ab", 1'b1);
  endtask

  // The later framing header wins, in both directions.
  task automatic test_header_order();
    send_text("R|Content-Length: 3|Transfer-Encoding: chunked||1|Q|0||", 1'b1);
    send_text("R|Transfer-Encoding: chunked|Content-Length: 2||hi", 1'b1);
  endtask

  // Chunk sizes with junk, then each way a chunk can go wrong.
  task automatic test_chunked();
    send_text("R|Transfer-Encoding: chunked||a|0123456789|2\015;|xy|0||", 1'b1);
    send_text("R|Transfer-Encoding: chunked||2|abX", 1'b1);
    send_text("R|Transfer-Encoding: chunked||1|a\015X", 1'b1);
    send_text("R|Transfer-Encoding: chunked||0|X-T: 1||", 1'b1);
    send_text("R|Transfer-Encoding: chunked||100001|", 1'b1);
  endtask

  // After message done or a framing error, bytes are dropped until a restart.
  task automatic test_after_end();
    send_text("R|Content-Length: 1||a", 1'b1);
    send_text("bcd|\015\n", 1'b0);
    send_text("R|Transfer-Encoding: chunked||1|a\015X", 1'b1);
    send_text("0||", 1'b0);
  endtask

  // Length limit at zero, at all ones, at a small value, and back to default.
  task automatic test_limit_extremes();
    set_limit(32'd0);
    send_text("R|Content-Length: 1||", 1'b1);
    send_text("R|Transfer-Encoding: chunked||0||", 1'b1);
    set_limit(32'hFFFF_FFFF);
    send_text("R|Content-Length: 99999999999||abc", 1'b1);
    send_text("R|Transfer-Encoding: chunked||FFFFFFFFFFF|xy", 1'b1);
    set_limit(32'd5);
    send_text("R|Content-Length: 5||abcde", 1'b1);
    set_limit(hrbd_pkg::LIMIT_RESET);
  endtask

  // Random messages over four idling mixes, each with its own length limit.
  task automatic test_random_traffic();
    int sent;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
          set_limit(hrbd_pkg::LIMIT_RESET);
        end
        1: begin
          send_gap_pct = 55;
          stall_pct = 0;
          set_limit(32'd20);
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 55;
          set_limit(32'($urandom_range(0, 30)));
        end
        default: begin
          send_gap_pct = 34;
          stall_pct = 34;
          set_limit($urandom);
        end
      endcase
      sent = 0;
      while (sent < RANDOM_BYTES_PER_PHASE) begin
        compose_message();
        sent += msg_q.size();
        send_msg(1'b1);
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_line_breaks();
    test_content_length();
    test_header_order();
    test_chunked();
    test_after_end();
    test_limit_extremes();
    test_random_traffic();
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/hrbd_pkg.sv
rtl/core/hrbd_in_stage.sv
rtl/core/hrbd_parser.sv
rtl/core/hrbd_out_stage.sv
rtl/core/http_response_body_deframer.sv
sim/tb_http_response_body_deframer.sv
